FILE: hw/rtl/spbd_pkg.sv
// shared types and constants for the sense bit payload decoder
// no dependencies; used by spbd_cell, spbd_chain and the top level
`timescale 1ns / 1ps

package spbd_pkg;

    // payload word and stream layout
    localparam int WORD_W      = 64;
    localparam int CELL_W      = WORD_W - 1;   // cells keep only the upper bits of a word
    localparam int LEN_IN_W    = 14;
    localparam int S_TDATA_W   = 80;
    localparam int S_DATA_LSB  = 0;
    localparam int S_LEN_LSB   = WORD_W;
    localparam int S_SENSE_BIT = WORD_W + LEN_IN_W;

    // kind codes carried on s_tuser
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_RAW   = 1'b1;

    // control from the sequencer to the cell chain
    typedef struct packed {
        logic wr_en;   // write the addressed cell
        logic shift;   // every cell takes its upper neighbor's word
    } chain_ctl_t;

endpackage

FILE: hw/rtl/spbd_cell.sv
// one storage cell of the group chain: loads when addressed, shifts toward the head
// depends on spbd_pkg
`timescale 1ns / 1ps

module spbd_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
) (
    input  logic                      aclk,
    input  spbd_pkg::chain_ctl_t      ctl,
    input  logic [IDX_W-1:0]          wr_idx,
    input  logic [spbd_pkg::CELL_W-1:0] wr_data,
    input  logic [spbd_pkg::CELL_W-1:0] up_data,
    output logic [spbd_pkg::CELL_W-1:0] data
);

    logic [spbd_pkg::CELL_W-1:0] data_reg;
    logic [spbd_pkg::CELL_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctl.wr_en && (wr_idx == IDX_W'(INDEX))) begin
            data_next = wr_data;
        end else if (ctl.shift) begin
            data_next = up_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: hw/rtl/spbd_chain.sv
// row of spbd_cell instances holding one group; cell 0 is the drain end
// depends on spbd_pkg and spbd_cell
`timescale 1ns / 1ps

module spbd_chain #(
    parameter int DEPTH = 63,
    parameter int IDX_W = 6
) (
    input  logic                        aclk,
    input  spbd_pkg::chain_ctl_t        ctl,
    input  logic [IDX_W-1:0]            wr_idx,
    input  logic [spbd_pkg::CELL_W-1:0] wr_data,
    output logic [spbd_pkg::CELL_W-1:0] head_data
);

    logic [spbd_pkg::CELL_W-1:0] cell_data [DEPTH+1];

    // nothing above the top cell
    assign cell_data[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spbd_cell #(
            .INDEX (i),
            .IDX_W (IDX_W)
        ) u_cell (
            .aclk    (aclk),
            .ctl     (ctl),
            .wr_idx  (wr_idx),
            .wr_data (wr_data),
            .up_data (cell_data[i+1]),
            .data    (cell_data[i])
        );
    end

    assign head_data = cell_data[0];

endmodule

FILE: hw/rtl/sense_bit_payload_decoder.sv
// sense bit payload decoder: group sequencer, true-bit restore and output register
// depends on spbd_pkg and spbd_chain
`timescale 1ns / 1ps

// usage
//   slave channel: s_tuser is the kind (start or raw ring word); s_tdata carries
//   data, length_words and sense. a start transaction latches the header word,
//   the expected sense and the length (saturated to MAX_WORDS); raw words whose
//   low bit differs from the sense, or that arrive while idle, are dropped.
//   words of a group are written into a row of cells one per transaction. when
//   the group is complete (header group) or its bit word arrives (later groups)
//   the row drains through cell 0, one word per cycle while m_tready allows, the low bit
//   of each word replaced from the bit source, onto the master channel (m_tdata, m_tlast).
//   the first word of a group passes the drain counter and then the output
//   register after the transaction that completes the group. a group of k words
//   takes k (header group) or k+1 (later groups) input transactions, and no input
//   is taken while it drains; the drain goes through the single shift path at cell 0.
//   s_tready is low while a group drains. a stalled m_tready holds the output
//   register and pauses the drain; the last drained word waits in the output
//   register while the next input transactions are accepted.
//   reset (aresetn low, synchronous) returns to idle with an empty output.
module sense_bit_payload_decoder #(
    parameter int GROUP_WORDS       = 63,
    parameter int FIRST_GROUP_WORDS = 32,
    parameter int MAX_WORDS         = 8192
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input transactions
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spbd_pkg::S_TDATA_W-1:0] s_tdata,   // data[63:0], length_words[77:64], sense[78]
    input  logic                           s_tuser,   // kind
    // result transactions
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spbd_pkg::WORD_W-1:0]    m_tdata,   // word[63:0]
    output logic                           m_tlast
);

    localparam int DEPTH = (GROUP_WORDS > FIRST_GROUP_WORDS) ? GROUP_WORDS : FIRST_GROUP_WORDS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_WORDS + 1);

    localparam logic [31:0] MAX_LEN   = 32'(MAX_WORDS);
    localparam logic [31:0] FIRST_LIM = 32'(FIRST_GROUP_WORDS);
    localparam logic [31:0] GROUP_LIM = 32'(GROUP_WORDS);

    // group size: words left clipped to the group limit
    function automatic logic [CNT_W-1:0] clip_size(input logic [31:0] wl, input logic [31:0] lim);
        return CNT_W'((wl < lim) ? wl : lim);
    endfunction

    // input field unpacking
    logic [spbd_pkg::WORD_W-1:0]   in_data;
    logic [spbd_pkg::LEN_IN_W-1:0] in_len;
    logic                          in_sense;
    logic [spbd_pkg::WORD_W:0]     in_data_ext;

    assign in_data     = s_tdata[spbd_pkg::S_DATA_LSB +: spbd_pkg::WORD_W];
    assign in_len      = s_tdata[spbd_pkg::S_LEN_LSB +: spbd_pkg::LEN_IN_W];
    assign in_sense    = s_tdata[spbd_pkg::S_SENSE_BIT];
    assign in_data_ext = {1'b0, in_data};

    // sequencer state
    logic                      busy_reg, busy_next;
    logic                      first_reg, first_next;
    logic                      sense_reg, sense_next;
    logic [CNT_W-1:0]          fill_reg, fill_next;
    logic [CNT_W-1:0]          size_reg, size_next;
    logic [LEN_W-1:0]          words_left_reg, words_left_next;
    logic [DEPTH-1:0]          header_reg, header_next;

    // drain state
    logic [CNT_W-1:0]          drain_cnt_reg, drain_cnt_next;
    logic [IDX_W-1:0]          bit_idx_reg, bit_idx_next;
    logic                      drain_last_reg, drain_last_next;
    logic [DEPTH-1:0]          bits_reg, bits_next;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic [spbd_pkg::WORD_W-1:0]   m_word_reg, m_word_next;
    logic                          m_last_reg, m_last_next;

    // chain interface
    spbd_pkg::chain_ctl_t          chain_ctl;
    logic [spbd_pkg::CELL_W-1:0]   head_data;

    // helpers
    logic                      s_fire;
    logic                      drain_go;
    logic [31:0]               len32;
    logic [LEN_W-1:0]          len_sat;
    logic [CNT_W-1:0]          fill_inc;
    logic [CNT_W-1:0]          size_m1;
    logic [31:0]               rem32;
    logic                      emit_en;
    logic [DEPTH-1:0]          emit_bits;

    assign s_tready = (drain_cnt_reg == '0);
    assign s_fire   = s_tvalid && s_tready;
    assign drain_go = (drain_cnt_reg != '0) && (!m_valid_reg || m_tready);

    assign len32    = 32'(in_len);
    assign len_sat  = (len32 > MAX_LEN) ? LEN_W'(MAX_LEN) : LEN_W'(len32);
    assign fill_inc = fill_reg + CNT_W'(1);
    assign size_m1  = size_reg - CNT_W'(1);
    assign rem32    = 32'(words_left_reg) - 32'(size_reg);

    always_comb begin
        busy_next       = busy_reg;
        first_next      = first_reg;
        sense_next      = sense_reg;
        fill_next       = fill_reg;
        size_next       = size_reg;
        words_left_next = words_left_reg;
        header_next     = header_reg;
        drain_cnt_next  = drain_cnt_reg;
        bit_idx_next    = bit_idx_reg;
        drain_last_next = drain_last_reg;
        bits_next       = bits_reg;
        m_valid_next    = m_valid_reg;
        m_word_next     = m_word_reg;
        m_last_next     = m_last_reg;
        chain_ctl.wr_en = 1'b0;
        chain_ctl.shift = 1'b0;
        emit_en         = 1'b0;
        emit_bits       = header_reg;

        // drain one word of the group per cycle into the output register while it is empty or being taken
        if (drain_go) begin
            chain_ctl.shift = 1'b1;
            m_valid_next    = 1'b1;
            m_word_next     = {head_data, bits_reg[bit_idx_reg]};
            m_last_next     = drain_last_reg && (drain_cnt_reg == CNT_W'(1));
            drain_cnt_next  = drain_cnt_reg - CNT_W'(1);
            bit_idx_next    = bit_idx_reg - IDX_W'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            if (s_tuser == spbd_pkg::KIND_START) begin
                // a start abandons any message in progress
                sense_next      = in_sense;
                header_next     = in_data[DEPTH-1:0];
                words_left_next = len_sat;
                first_next      = 1'b1;
                fill_next       = '0;
                size_next       = clip_size(32'(len_sat), FIRST_LIM);
                busy_next       = (len_sat != '0);
            end else if (busy_reg && (in_data[0] == sense_reg)) begin
                if (fill_reg < size_reg) begin
                    chain_ctl.wr_en = 1'b1;
                    fill_next       = fill_inc;
                    if (first_reg && (fill_inc == size_reg)) begin
                        emit_en   = 1'b1;
                        emit_bits = header_reg;
                    end
                end else begin
                    // group full: this word carries the true bits from bit 1 up
                    emit_en   = 1'b1;
                    emit_bits = in_data_ext[DEPTH:1];
                end
            end
        end

        if (emit_en) begin
            bits_next       = emit_bits;
            drain_cnt_next  = size_reg;
            bit_idx_next    = size_m1[IDX_W-1:0];
            drain_last_next = (rem32 == '0);
            words_left_next = LEN_W'(rem32);
            first_next      = 1'b0;
            fill_next       = '0;
            size_next       = clip_size(rem32, GROUP_LIM);
            busy_next       = (rem32 != '0);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            first_reg      <= 1'b1;
            sense_reg      <= 1'b0;
            fill_reg       <= '0;
            size_reg       <= '0;
            words_left_reg <= '0;
            drain_cnt_reg  <= '0;
            bit_idx_reg    <= '0;
            drain_last_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            first_reg      <= first_next;
            sense_reg      <= sense_next;
            fill_reg       <= fill_next;
            size_reg       <= size_next;
            words_left_reg <= words_left_next;
            drain_cnt_reg  <= drain_cnt_next;
            bit_idx_reg    <= bit_idx_next;
            drain_last_reg <= drain_last_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        header_reg <= header_next;
        bits_reg   <= bits_next;
        m_word_reg <= m_word_next;
        m_last_reg <= m_last_next;
    end

    // group storage: written at the fill index, drained through cell 0
    spbd_chain #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (chain_ctl),
        .wr_idx    (fill_reg[IDX_W-1:0]),
        .wr_data   (in_data[spbd_pkg::WORD_W-1:1]),
        .head_data (head_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tlast  = m_last_reg;

endmodule
